// ===== rtl/prqs_pkg.sv =====
// Package with sizes, command codes and controller/datapath link types of the scheduler.
`timescale 1ns / 1ps
`default_nettype none
package prqs_pkg;

  localparam int THREAD_SLOTS    = 8;
  localparam int PRIORITY_LEVELS = 16;

  // Slot numbers carry one extra code that means no slot.
  localparam int SLOT_W = $clog2(THREAD_SLOTS + 1);
  localparam int SIDX_W = $clog2(THREAD_SLOTS);
  localparam int PRI_W  = $clog2(PRIORITY_LEVELS);

  // Fixed field widths of the words on the channels.
  localparam int CMD_W  = 4;
  localparam int PREQ_W = 4;
  localparam int TGT_W  = 3;
  localparam int VAL_W  = 4;
  localparam int NEXT_W = 4;

  localparam logic [SLOT_W-1:0] NO_SLOT = SLOT_W'(THREAD_SLOTS);

  // Kernel event codes; codes above CMD_INTR act as a plain interrupt.
  localparam logic [CMD_W-1:0] CMD_CREATE  = 4'd0;
  localparam logic [CMD_W-1:0] CMD_EXIT    = 4'd1;
  localparam logic [CMD_W-1:0] CMD_WAIT    = 4'd2;
  localparam logic [CMD_W-1:0] CMD_SLEEP   = 4'd3;
  localparam logic [CMD_W-1:0] CMD_WAKEUP  = 4'd4;
  localparam logic [CMD_W-1:0] CMD_GETID   = 4'd5;
  localparam logic [CMD_W-1:0] CMD_CHPRI   = 4'd6;
  localparam logic [CMD_W-1:0] CMD_SOFTERR = 4'd7;
  localparam logic [CMD_W-1:0] CMD_INTR    = 4'd8;

  // Datapath operations, at most one set per cycle.
  typedef struct packed {
    logic load;
    logic take;
    logic alloc;
    logic put;
    logic setcur;
    logic chp;
    logic clr;
    logic getid;
    logic sel;
  } dp_cmd_t;

  // Datapath status seen by the controller.
  typedef struct packed {
    logic             halted;
    logic [CMD_W-1:0] cmd;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/prqs_if.sv =====
// Channel interfaces for kernel event words and scheduler result words.
`timescale 1ns / 1ps
`default_nettype none
interface prqs_req_if;
  logic       valid;
  logic       ready;
  logic [3:0] cmd;
  logic [3:0] priority_req;
  logic [2:0] target_thread;

  modport source (output valid, cmd, priority_req, target_thread, input ready);
  modport sink (input valid, cmd, priority_req, target_thread, output ready);
endinterface

interface prqs_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] result_value;
  logic       result_fail;
  logic [3:0] next_thread;
  logic       system_down;

  modport source (output valid, result_value, result_fail, next_thread, system_down,
                  input ready);
  modport sink (input valid, result_value, result_fail, next_thread, system_down,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/prqs_dp.sv =====
// Scheduler datapath: slot table, ready lists, current thread and result registers.
`timescale 1ns / 1ps
`default_nettype none
module prqs_dp import prqs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dp_cmd_t           cmd,
  output      dp_stat_t          stat,
  input  wire logic [CMD_W-1:0]  cmd_in,
  input  wire logic [PREQ_W-1:0] priority_req,
  input  wire logic [TGT_W-1:0]  target_thread,
  output      logic [VAL_W-1:0]  result_value,
  output      logic              result_fail,
  output      logic [NEXT_W-1:0] next_thread,
  output      logic              system_down
);

  logic                  in_use   [THREAD_SLOTS];
  logic                  ready    [THREAD_SLOTS];
  logic [PRI_W-1:0]      prio     [THREAD_SLOTS];
  logic [SLOT_W-1:0]     link     [THREAD_SLOTS];
  logic [SLOT_W-1:0]     head     [PRIORITY_LEVELS];
  logic [SLOT_W-1:0]     tail     [PRIORITY_LEVELS];
  logic [SLOT_W-1:0]     cur;
  logic                  halted;
  logic [CMD_W-1:0]      cmd_q;
  logic [PRI_W-1:0]      pri_q;
  logic [TGT_W-1:0]      tgt_q;
  logic [VAL_W-1:0]      value;
  logic                  fail;
  logic [SLOT_W-1:0]     newslot;
  logic                  have_new;

  logic                  cur_ok;
  logic [SIDX_W-1:0]     cidx;
  logic [PRI_W-1:0]      cp;
  logic [SLOT_W-1:0]     cl;
  logic                  cr;
  logic [SLOT_W-1:0]     t;
  logic                  tok;
  logic [SIDX_W-1:0]     tidx;
  logic                  free_found;
  logic [SIDX_W-1:0]     free_idx;
  logic                  sel_found;
  logic [SLOT_W-1:0]     sel_slot;
  logic [PRI_W-1:0]      pri_clamp;
  logic                  tgt_ok;
  logic [SIDX_W-1:0]     gidx;

  assign stat.halted = halted;
  assign stat.cmd    = cmd_q;

  // Current slot and the list it sits on.
  assign cur_ok = (cur < NO_SLOT);
  assign cidx   = cur[SIDX_W-1:0];
  assign cp     = prio[cidx];
  assign cl     = link[cidx];
  assign cr     = ready[cidx];
  assign t      = tail[cp];
  assign tok    = (t < NO_SLOT);
  assign tidx   = t[SIDX_W-1:0];

  // Wakeup target check.
  assign gidx   = SIDX_W'(tgt_q);
  assign tgt_ok = (int'(tgt_q) < THREAD_SLOTS) && in_use[gidx];

  // Requested priority saturates at the lowest level.
  always_comb begin
    if (int'(priority_req) >= PRIORITY_LEVELS) begin
      pri_clamp = PRI_W'(PRIORITY_LEVELS - 1);
    end else begin
      pri_clamp = PRI_W'(priority_req);
    end
  end

  // Lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = THREAD_SLOTS - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_found = 1'b1;
        free_idx   = SIDX_W'(i);
      end
    end
  end

  // Head of the highest non-empty priority list.
  always_comb begin
    sel_found = 1'b0;
    sel_slot  = NO_SLOT;
    for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
      if (head[i] < NO_SLOT) begin
        sel_found = 1'b1;
        sel_slot  = head[i];
      end
    end
  end

  // Table and list updates, one operation per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < THREAD_SLOTS; i++) begin
        in_use[i] <= 1'b0;
        ready[i]  <= 1'b0;
        prio[i]   <= '0;
        link[i]   <= NO_SLOT;
      end
      for (int i = 0; i < PRIORITY_LEVELS; i++) begin
        head[i] <= NO_SLOT;
        tail[i] <= NO_SLOT;
      end
      cur    <= NO_SLOT;
      halted <= 1'b0;
    end else if (cmd.take) begin
      if (cur_ok && cr) begin
        head[cp] <= cl;
        if (!(cl < NO_SLOT)) begin
          tail[cp] <= NO_SLOT;
        end
        ready[cidx] <= 1'b0;
        link[cidx]  <= NO_SLOT;
      end
    end else if (cmd.alloc) begin
      if (free_found) begin
        in_use[free_idx] <= 1'b1;
        ready[free_idx]  <= 1'b0;
        prio[free_idx]   <= pri_q;
        link[free_idx]   <= NO_SLOT;
      end
    end else if (cmd.put) begin
      if (cur_ok && !cr) begin
        if (tok) begin
          link[tidx] <= cur;
        end else begin
          head[cp] <= cur;
        end
        tail[cp]    <= cur;
        link[cidx]  <= NO_SLOT;
        ready[cidx] <= 1'b1;
      end
    end else if (cmd.setcur) begin
      if (cmd_q == CMD_CREATE) begin
        if (have_new) begin
          cur <= newslot;
        end
      end else if (tgt_ok) begin
        cur <= SLOT_W'(tgt_q);
      end
    end else if (cmd.chp) begin
      if (cur_ok) begin
        prio[cidx] <= pri_q;
      end
    end else if (cmd.clr) begin
      if (cur_ok) begin
        in_use[cidx] <= 1'b0;
        ready[cidx]  <= 1'b0;
        prio[cidx]   <= '0;
        link[cidx]   <= NO_SLOT;
      end
    end else if (cmd.sel) begin
      cur <= sel_slot;
      if (!sel_found) begin
        halted <= 1'b1;
      end
    end
  end

  // Event word latch and per-event answer.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q    <= cmd_in;
      pri_q    <= pri_clamp;
      tgt_q    <= target_thread;
      value    <= '0;
      fail     <= 1'b0;
      have_new <= 1'b0;
    end else if (cmd.alloc) begin
      if (free_found) begin
        newslot  <= SLOT_W'(free_idx);
        value    <= VAL_W'(free_idx);
        have_new <= 1'b1;
      end else begin
        fail <= 1'b1;
      end
    end else if (cmd.chp) begin
      if (cur_ok) begin
        value <= VAL_W'(cp);
      end
    end else if (cmd.getid) begin
      if (cur_ok) begin
        value <= VAL_W'(cur);
      end
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (cmd.sel) begin
      result_value <= value;
      result_fail  <= fail;
      next_thread  <= NEXT_W'(sel_slot);
      system_down  <= halted | !sel_found;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/prqs_ctrl.sv =====
// Scheduler controller: sequences the datapath steps of each kernel event.
`timescale 1ns / 1ps
`default_nettype none
module prqs_ctrl import prqs_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output      logic     in_ready,
  output      logic     out_valid,
  input  wire logic     out_ready,
  output      dp_cmd_t  cmd,
  input  wire dp_stat_t stat
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_TAKE   = 10'b0000000010,
    ST_ALLOC  = 10'b0000000100,
    ST_PUT1   = 10'b0000001000,
    ST_SETCUR = 10'b0000010000,
    ST_PUT2   = 10'b0000100000,
    ST_CHP    = 10'b0001000000,
    ST_CLR    = 10'b0010000000,
    ST_GETID  = 10'b0100000000,
    ST_SEL    = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   kernel;
  logic   out_free;

  // Codes above soft error leave the current thread on its list.
  assign kernel   = (stat.cmd <= CMD_SOFTERR);
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  // Next state and datapath operations.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_TAKE;
        end
      end
      ST_TAKE: begin
        if (stat.halted || !kernel) begin
          state_next = ST_SEL;
        end else begin
          cmd.take = 1'b1;
          case (stat.cmd)
            CMD_CREATE:                              state_next = ST_ALLOC;
            CMD_EXIT, CMD_SOFTERR:                   state_next = ST_CLR;
            CMD_WAIT, CMD_WAKEUP, CMD_GETID:         state_next = ST_PUT1;
            CMD_CHPRI:                               state_next = ST_CHP;
            default:                                 state_next = ST_SEL;
          endcase
        end
      end
      ST_ALLOC: begin
        cmd.alloc  = 1'b1;
        state_next = ST_PUT1;
      end
      ST_PUT1: begin
        cmd.put = 1'b1;
        case (stat.cmd)
          CMD_CREATE, CMD_WAKEUP: state_next = ST_SETCUR;
          CMD_GETID:              state_next = ST_GETID;
          default:                state_next = ST_SEL;
        endcase
      end
      ST_SETCUR: begin
        cmd.setcur = 1'b1;
        state_next = ST_PUT2;
      end
      ST_CHP: begin
        cmd.chp    = 1'b1;
        state_next = ST_PUT2;
      end
      ST_PUT2: begin
        cmd.put    = 1'b1;
        state_next = ST_SEL;
      end
      ST_CLR: begin
        cmd.clr    = 1'b1;
        state_next = ST_SEL;
      end
      ST_GETID: begin
        cmd.getid  = 1'b1;
        state_next = ST_SEL;
      end
      ST_SEL: begin
        if (out_free) begin
          cmd.sel    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result word valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.sel) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/priority_ready_queue_scheduler.sv =====
// Fixed-priority FIFO ready-queue thread scheduler, top level.
// The event word is latched on acceptance; the controller runs the steps the event needs
// (an interrupt or a halted scheduler goes from TAKE to SEL), then registers the result word
// in SEL. No new event word is taken until then; the controller walks the shared slot
// table and lists one step per cycle and holds in SEL while the result is unread.
// Reset: synchronous, all ready lists empty, no current thread, not halted; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module priority_ready_queue_scheduler import prqs_pkg::*; (
  input wire logic   clk,
  input wire logic   rst,
  prqs_req_if.sink   req,
  prqs_rsp_if.source rsp
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Event sequencing.
  prqs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Thread table, ready lists and result word.
  prqs_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cmd_in        (req.cmd),
    .priority_req  (req.priority_req),
    .target_thread (req.target_thread),
    .result_value  (rsp.result_value),
    .result_fail   (rsp.result_fail),
    .next_thread   (rsp.next_thread),
    .system_down   (rsp.system_down)
  );

endmodule
`default_nettype wire
